[rtl/core/est_pkg.sv]
// Shared types and character constants for the escape-styled text tokenizer.
package est_pkg;

	localparam logic [7:0] CH_ESC   = 8'h1B;
	localparam logic [7:0] CH_CR    = 8'h0D;
	localparam logic [7:0] CH_LF    = 8'h0A;
	localparam logic [7:0] CH_TAB   = 8'h09;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] MARK_0   = 8'hEF;
	localparam logic [7:0] MARK_1   = 8'hBB;
	localparam logic [7:0] MARK_2   = 8'hBF;

	localparam int MAX_RESULTS = 3;

	typedef enum logic [1:0] {
		KIND_WORD    = 2'd0,
		KIND_SPACE   = 2'd1,
		KIND_NEWLINE = 2'd2,
		KIND_TAB     = 2'd3
	} kind_t;

	localparam logic [2:0] STYLE_REGULAR     = 3'd0;
	localparam logic [2:0] STYLE_BOLD        = 3'd1;
	localparam logic [2:0] STYLE_ITALIC      = 3'd2;
	localparam logic [2:0] STYLE_BOLD_ITALIC = 3'd3;
	localparam logic [2:0] STYLE_HIDDEN      = 3'd4;

	localparam logic [2:0] ALIGN_NONE    = 3'd0;
	localparam logic [2:0] ALIGN_LEFT    = 3'd1;
	localparam logic [2:0] ALIGN_RIGHT   = 3'd2;
	localparam logic [2:0] ALIGN_CENTER  = 3'd3;
	localparam logic [2:0] ALIGN_JUSTIFY = 3'd4;

	typedef struct packed {
		logic [7:0] out_char;
		kind_t      kind;
		logic [2:0] style;
		logic [2:0] align;
		logic       start;
	} result_t;

	typedef struct packed {
		logic [1:0]  cnt;
		result_t [2:0] slot;
	} burst_t;

endpackage

[rtl/core/est_parser.sv]
// Input register, tokenizer state and the decode of one byte into a burst of results.
module est_parser (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          text_valid,
	output logic          text_ready,
	input  logic [7:0]    text_byte,
	input  logic          end_of_text,
	input  logic          can_load,
	output logic          load,
	output est_pkg::burst_t burst
);
	import est_pkg::*;

	typedef struct packed {
		logic [1:0] bom_phase;
		logic       bom_done;
		logic       escape_pending;
		logic [2:0] style;
		logic [2:0] align;
		logic       inside_word;
	} est_state_t;

	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       last_s1;
	est_state_t st_q;
	est_state_t nxt;

	logic [7:0] cand [MAX_RESULTS];
	logic [1:0] ncand;
	logic [1:0] nflush;
	logic       handle;
	logic       cmd_taken;
	logic       match;
	kind_t      kd;

	function automatic logic [7:0] mark_byte(input logic [1:0] idx);
		case (idx)
			2'd0:    return MARK_0;
			2'd1:    return MARK_1;
			default: return MARK_2;
		endcase
	endfunction

	function automatic kind_t kind_of(input logic [7:0] ch);
		case (ch)
			CH_SPACE: return KIND_SPACE;
			CH_LF:    return KIND_NEWLINE;
			CH_TAB:   return KIND_TAB;
			default:  return KIND_WORD;
		endcase
	endfunction

	assign text_ready = !valid_s1 || can_load;
	assign load       = valid_s1 && can_load;

	always_comb begin
		nxt       = st_q;
		burst     = '0;
		ncand     = 2'd0;
		nflush    = 2'd0;
		handle    = 1'b0;
		cmd_taken = 1'b0;
		match     = 1'b0;
		kd        = KIND_WORD;
		for (int i = 0; i < MAX_RESULTS; i++) begin
			cand[i[1:0]] = 8'h00;
		end

		if (!st_q.bom_done) begin
			match = (st_q.bom_phase != 2'd3) && (byte_s1 == mark_byte(st_q.bom_phase));
			if (match) begin
				if (st_q.bom_phase == 2'd2) begin
					nxt.bom_phase = 2'd0;
					nxt.bom_done  = 1'b1;
				end else begin
					nxt.bom_phase = st_q.bom_phase + 2'd1;
					if (last_s1) begin
						nflush = st_q.bom_phase + 2'd1;
					end
				end
			end else begin
				// A broken mark prefix goes out ahead of the byte that broke it.
				nflush        = (st_q.bom_phase == 2'd3) ? 2'd2 : st_q.bom_phase;
				nxt.bom_phase = 2'd0;
				nxt.bom_done  = 1'b1;
				handle        = 1'b1;
			end
		end else begin
			handle = 1'b1;
		end

		for (int i = 0; i < 2; i++) begin
			if (2'(i) < nflush) begin
				cand[ncand] = mark_byte(2'(i));
				ncand       = ncand + 2'd1;
			end
		end

		if (handle) begin
			if (st_q.escape_pending) begin
				nxt.escape_pending = 1'b0;
				cmd_taken          = 1'b1;
				case (byte_s1)
					"L": nxt.align = ALIGN_LEFT;
					"R": nxt.align = ALIGN_RIGHT;
					"C": nxt.align = ALIGN_CENTER;
					"J": nxt.align = ALIGN_JUSTIFY;
					"l", "r", "c", "j": nxt.align = ALIGN_NONE;
					"B": nxt.style = STYLE_BOLD;
					"I", "O": nxt.style = STYLE_ITALIC;
					"X": nxt.style = STYLE_BOLD_ITALIC;
					"H": nxt.style = STYLE_HIDDEN;
					"b", "i", "x", "h", "o": nxt.style = STYLE_REGULAR;
					default: cmd_taken = 1'b0;
				endcase
				if (cmd_taken) begin
					nxt.inside_word = 1'b0;
				end else if (ncand != 2'd3) begin
					cand[ncand] = CH_ESC;
					ncand       = ncand + 2'd1;
				end
			end
			if (!cmd_taken) begin
				if (byte_s1 == CH_ESC) begin
					if (last_s1) begin
						if (ncand != 2'd3) begin
							cand[ncand] = byte_s1;
							ncand       = ncand + 2'd1;
						end
					end else begin
						nxt.escape_pending = 1'b1;
					end
				end else if (byte_s1 != CH_CR) begin
					if (ncand != 2'd3) begin
						cand[ncand] = byte_s1;
						ncand       = ncand + 2'd1;
					end
				end
			end
		end

		// Tag each emitted character in order; only a newline changes alignment.
		for (int i = 0; i < MAX_RESULTS; i++) begin
			if (2'(i) < ncand) begin
				kd = kind_of(cand[i[1:0]]);
				if (kd != KIND_WORD) begin
					nxt.inside_word = 1'b0;
					if (kd == KIND_NEWLINE) begin
						nxt.align = ALIGN_NONE;
					end
					burst.slot[i[1:0]].start = 1'b1;
				end else begin
					burst.slot[i[1:0]].start = !nxt.inside_word;
					nxt.inside_word          = 1'b1;
				end
				burst.slot[i[1:0]].out_char = cand[i[1:0]];
				burst.slot[i[1:0]].kind     = kd;
				burst.slot[i[1:0]].style    = nxt.style;
				burst.slot[i[1:0]].align    = nxt.align;
			end
		end
		burst.cnt = ncand;

		if (last_s1) begin
			nxt = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			st_q     <= '0;
		end else begin
			if (text_ready) begin
				valid_s1 <= text_valid;
			end
			if (load) begin
				st_q <= nxt;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (text_ready && text_valid) begin
			byte_s1 <= text_byte;
			last_s1 <= end_of_text;
		end
	end

endmodule

[rtl/core/est_burst.sv]
// Result buffer that holds the results of one item and hands them out one per cycle while tok_ready is high.
module est_burst (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          load,
	input  est_pkg::burst_t burst,
	output logic          can_load,
	output logic          tok_valid,
	input  logic          tok_ready,
	output est_pkg::result_t cur,
	output logic          last
);
	import est_pkg::*;

	result_t    buf_q [MAX_RESULTS];
	logic [1:0] cnt_q;
	logic [1:0] idx_q;
	logic       taking;
	logic       finishing;

	assign tok_valid = (cnt_q != 2'd0);
	assign cur       = buf_q[idx_q];
	assign last      = (idx_q == cnt_q - 2'd1);
	assign taking    = tok_valid && tok_ready;
	assign finishing = taking && last;
	assign can_load  = !tok_valid || finishing;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= 2'd0;
			idx_q <= 2'd0;
		end else if (load) begin
			cnt_q <= burst.cnt;
			idx_q <= 2'd0;
		end else if (finishing) begin
			cnt_q <= 2'd0;
			idx_q <= 2'd0;
		end else if (taking) begin
			idx_q <= idx_q + 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			for (int i = 0; i < MAX_RESULTS; i++) begin
				buf_q[i[1:0]] <= burst.slot[i[1:0]];
			end
		end
	end

endmodule

[rtl/core/escape_styled_text_tokenizer.sv]
// Top level of the escape-styled text tokenizer.
// Bytes enter through an input register and are decoded in one pass into up to three
// results, which a three-entry result buffer hands out one per cycle while tok_ready
// is high. Plain text then streams at one byte per clock; a byte that yields more than
// one result holds the result buffer until all have gone out, and the input register takes
// one more byte while that buffer drains. End of text flushes held mark or escape bytes and
// returns the tokenizer to its start state.
module escape_styled_text_tokenizer (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       text_valid,
	output logic       text_ready,
	input  logic [7:0] text_byte,
	input  logic       end_of_text,
	output logic       tok_valid,
	input  logic       tok_ready,
	output logic [7:0] out_char,
	output logic [1:0] char_kind,
	output logic [2:0] text_style,
	output logic [2:0] paragraph_align,
	output logic       token_start,
	output logic       last_of_run
);
	import est_pkg::*;

	burst_t  burst;
	result_t cur;
	logic    load;
	logic    can_load;

	est_parser u_parser (
		.clk        (clk),
		.arst_n     (arst_n),
		.text_valid (text_valid),
		.text_ready (text_ready),
		.text_byte  (text_byte),
		.end_of_text(end_of_text),
		.can_load   (can_load),
		.load       (load),
		.burst      (burst)
	);

	est_burst u_burst (
		.clk      (clk),
		.arst_n   (arst_n),
		.load     (load),
		.burst    (burst),
		.can_load (can_load),
		.tok_valid(tok_valid),
		.tok_ready(tok_ready),
		.cur      (cur),
		.last     (last_of_run)
	);

	assign out_char        = cur.out_char;
	assign char_kind       = cur.kind;
	assign text_style      = cur.style;
	assign paragraph_align = cur.align;
	assign token_start     = cur.start;

endmodule

[rtl/core/est_checker.sv]
// Port-level checks on the tokenizer's result channel, bound to the top level.
module est_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       tok_valid,
	input logic       tok_ready,
	input logic [7:0] out_char,
	input logic [1:0] char_kind,
	input logic [2:0] text_style,
	input logic [2:0] paragraph_align,
	input logic       token_start,
	input logic       last_of_run
);
	import est_pkg::*;

	// A stalled result holds its value.
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		tok_valid && !tok_ready |=> tok_valid && $stable(out_char) && $stable(char_kind)
			&& $stable(last_of_run))
		else $error("result changed while stalled");

	// A space byte always goes out as a space token and nothing else does.
	a_space: assert property (@(posedge clk) disable iff (!arst_n)
		tok_valid |-> ((out_char == CH_SPACE) == (char_kind == KIND_SPACE)))
		else $error("space kind mismatch");

	// Whitespace tokens are one byte long, so each starts a token.
	a_ws_start: assert property (@(posedge clk) disable iff (!arst_n)
		tok_valid && (char_kind != KIND_WORD) |-> token_start)
		else $error("whitespace without token start");

	// A newline clears the alignment before it goes out.
	a_nl_align: assert property (@(posedge clk) disable iff (!arst_n)
		tok_valid && (char_kind == KIND_NEWLINE) |-> (paragraph_align == ALIGN_NONE))
		else $error("newline carries an alignment");

	a_codes: assert property (@(posedge clk) disable iff (!arst_n)
		tok_valid |-> (text_style <= STYLE_HIDDEN) && (paragraph_align <= ALIGN_JUSTIFY))
		else $error("style or alignment code out of range");

endmodule

bind escape_styled_text_tokenizer est_checker u_est_checker (.*);
